>>> rtl/core/fbl_pkg.sv
// Shared types, codes and default sizes for the free block list allocator.
`default_nettype none

package fbl_pkg;

  // Default sizes handed to the top level parameters
  localparam int unsigned DepthDefault     = 1024;
  localparam int unsigned BlockBitsDefault = 16;

  // Fixed field widths of the item and configuration ports
  localparam int unsigned BLK_W      = 16;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned COUNT_W    = 11;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Register reset values
  localparam logic [BLK_W-1:0] FIRST_BLOCK_RST = 16'd1;
  localparam logic [BLK_W-1:0] LAST_BLOCK_RST  = 16'd1024;

  typedef enum logic [CMD_W-1:0] {
    CMD_REBUILD = 2'd0,
    CMD_ALLOC   = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_NOP     = 2'd3
  } fbl_cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } fbl_status_e;

  // Register index, taken from address bit 2
  typedef enum logic {
    REG_FIRST_BLOCK = 1'b0,
    REG_LAST_BLOCK  = 1'b1
  } fbl_reg_e;

  typedef struct packed {
    logic [BLK_W-1:0] first_block;
    logic [BLK_W-1:0] last_block;
  } fbl_cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/fbl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module fbl_ram #(
  parameter int unsigned WIDTH = fbl_pkg::BlockBitsDefault,
  parameter int unsigned DEPTH = fbl_pkg::DepthDefault
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/fbl_cfg.sv
// APB-style register file for the rebuild range.
`default_nettype none

module fbl_cfg (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [fbl_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [fbl_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic      [fbl_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                   pready,
  output fbl_pkg::fbl_cfg_t                      cfg_o
);
  import fbl_pkg::*;

  fbl_cfg_t cfg_q, cfg_d;
  logic     wr_en;
  fbl_reg_e reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = fbl_reg_e'(paddr[2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_FIRST_BLOCK: cfg_d.first_block = pwdata[BLK_W-1:0];
        REG_LAST_BLOCK:  cfg_d.last_block  = pwdata[BLK_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_FIRST_BLOCK: prdata = CFG_DATA_W'(cfg_q.first_block);
      REG_LAST_BLOCK:  prdata = CFG_DATA_W'(cfg_q.last_block);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_block <= FIRST_BLOCK_RST;
      cfg_q.last_block  <= LAST_BLOCK_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> rtl/core/free_block_list_allocator.sv
// Top level: FIFO free list of block numbers held in one ring RAM.
// Results: release and no-op results show the cycle after the transfer; an allocate result
//   passes through the RAM read register and S_READ; a rebuild answers after its S_FILL walk.
// Throughput: one release or no-op per cycle unless the result channel stalls; an allocate
//   holds off commands through S_READ; rebuild writes one ring entry per cycle through the single RAM write port.
// Reset: head, tail and count cleared, list empty; ring contents are not cleared.
`default_nettype none

module free_block_list_allocator #(
  parameter int unsigned DEPTH      = fbl_pkg::DepthDefault,
  parameter int unsigned BLOCK_BITS = fbl_pkg::BlockBitsDefault
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // command channel
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [fbl_pkg::CMD_W-1:0]       cmd_i,
  input  wire logic [fbl_pkg::BLK_W-1:0]       block_in_i,
  // result channel
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic      [fbl_pkg::BLK_W-1:0]       block_out_o,
  output logic      [fbl_pkg::STATUS_W-1:0]    status_o,
  output logic      [fbl_pkg::COUNT_W-1:0]     free_count_o,
  // configuration port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [fbl_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [fbl_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [fbl_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                 pready
);
  import fbl_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);      // ring index
  localparam int unsigned CW = $clog2(DEPTH + 1);  // entry count, holds DEPTH itself
  localparam int unsigned NW = BLK_W + 1;          // rebuild walker, may pass 65535

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_FILL = 3'b100
  } fbl_state_e;

  fbl_cfg_t cfg;

  fbl_state_e state_q, state_d;
  logic [IW-1:0] head_q, head_d;
  logic [IW-1:0] tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;
  logic [NW-1:0] fill_n_q, fill_n_d;

  // output register
  logic                out_valid_q, out_valid_d;
  logic [BLK_W-1:0]    out_block_q, out_block_d;
  fbl_status_e         out_status_q, out_status_d;
  logic [COUNT_W-1:0]  out_count_q, out_count_d;

  // RAM port signals
  logic                  ram_we;
  logic [BLOCK_BITS-1:0] ram_wdata;
  logic                  ram_re;
  logic [BLOCK_BITS-1:0] ram_rdata;

  logic in_xfer, out_xfer, list_full, fill_done;

  function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] pos);
    return (pos == IW'(DEPTH - 1)) ? '0 : pos + 1'b1;
  endfunction

  fbl_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Writes always land at the tail; the only read is the head on allocate.
  // One command is in flight at a time, so a read never meets a write to the
  // same entry in the same cycle.
  fbl_ram #(
    .WIDTH (BLOCK_BITS),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  assign out_xfer  = out_valid_q && !out_stall_i;
  // Take a command only when idle and the output register is free at this edge.
  assign in_stall_o = !((state_q == S_IDLE) && (!out_valid_q || !out_stall_i));
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign list_full = (count_q == CW'(DEPTH));
  // Rebuild finishes past last_block or once the ring is full.
  assign fill_done = (fill_n_q > {1'b0, cfg.last_block}) || list_full;

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    fill_n_d     = fill_n_q;
    ram_we       = 1'b0;
    ram_wdata    = BLOCK_BITS'(block_in_i);
    ram_re       = 1'b0;
    out_valid_d  = out_valid_q && !out_xfer;
    out_block_d  = out_block_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          unique case (fbl_cmd_e'(cmd_i))
            CMD_REBUILD: begin
              // empty the list, then walk the range in S_FILL
              head_d   = '0;
              tail_d   = '0;
              count_d  = '0;
              fill_n_d = {1'b0, cfg.first_block};
              state_d  = S_FILL;
            end
            CMD_ALLOC: begin
              if (count_q == '0) begin
                out_valid_d  = 1'b1;
                out_block_d  = '0;
                out_status_d = STATUS_EMPTY;
                out_count_d  = COUNT_W'(count_q);
              end else begin
                // issue head read, result follows from S_READ
                ram_re  = 1'b1;
                head_d  = ring_next(head_q);
                count_d = count_q - 1'b1;
                state_d = S_READ;
              end
            end
            CMD_RELEASE: begin
              out_valid_d = 1'b1;
              out_block_d = '0;
              if (list_full) begin
                // drop the number and flag it
                out_status_d = STATUS_FULL;
                out_count_d  = COUNT_W'(count_q);
              end else begin
                ram_we       = 1'b1;
                tail_d       = ring_next(tail_q);
                count_d      = count_q + 1'b1;
                out_status_d = STATUS_OK;
                out_count_d  = COUNT_W'(count_d);
              end
            end
            CMD_NOP: begin
              out_valid_d  = 1'b1;
              out_block_d  = '0;
              out_status_d = STATUS_OK;
              out_count_d  = COUNT_W'(count_q);
            end
          endcase
        end
      end
      S_READ: begin
        out_valid_d  = 1'b1;
        out_block_d  = BLK_W'(ram_rdata);
        out_status_d = STATUS_OK;
        out_count_d  = COUNT_W'(count_q);
        state_d      = S_IDLE;
      end
      S_FILL: begin
        if (fill_done) begin
          out_valid_d  = 1'b1;
          out_block_d  = '0;
          out_status_d = STATUS_OK;
          out_count_d  = COUNT_W'(count_q);
          state_d      = S_IDLE;
        end else begin
          // append one block number per cycle
          ram_we    = 1'b1;
          ram_wdata = BLOCK_BITS'(fill_n_q[BLK_W-1:0]);
          tail_d    = ring_next(tail_q);
          count_d   = count_q + 1'b1;
          fill_n_d  = fill_n_q + 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    fill_n_q     <= fill_n_d;
    out_block_q  <= out_block_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
  end

  assign out_valid_o  = out_valid_q;
  assign block_out_o  = out_block_q;
  assign status_o     = out_status_q;
  assign free_count_o = out_count_q;

endmodule

`default_nettype wire

>>> rtl/core/fbl_checker.sv
// Port-level checks on the result channel of the free block list allocator.
`default_nettype none

module fbl_checker #(
  parameter int unsigned DEPTH = fbl_pkg::DepthDefault
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic [fbl_pkg::BLK_W-1:0]     block_out_o,
  input wire logic [fbl_pkg::STATUS_W-1:0]  status_o,
  input wire logic [fbl_pkg::COUNT_W-1:0]   free_count_o
);
  import fbl_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(block_out_o)
      && $stable(status_o) && $stable(free_count_o))
    else $error("stalled result changed");

  // empty status only on an empty list, with no block
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_EMPTY) |-> (block_out_o == '0)
      && (free_count_o == '0))
    else $error("empty status with block or nonzero count");

  // a dropped release reports a full list
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_FULL) |-> (block_out_o == '0)
      && (free_count_o == COUNT_W'(DEPTH)))
    else $error("full status without a full list");

  // count never exceeds the ring size
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (DEPTH >= (1 << COUNT_W)) || (free_count_o <= COUNT_W'(DEPTH)))
    else $error("free count above ring depth");

endmodule

bind free_block_list_allocator fbl_checker #(
  .DEPTH (DEPTH)
) u_fbl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .block_out_o  (block_out_o),
  .status_o     (status_o),
  .free_count_o (free_count_o)
);

`default_nettype wire
